/* sv/bbi_pkg.sv */
// box boundary impulse: shared types and constants
// no dependencies; imported by bbi_axis and box_boundary_impulse
`default_nettype none

package bbi_pkg;

	localparam int Q_ONE = 65536;
	localparam logic [30:0] DEPTH_MAX = 31'h7FFF_FFFF;

	// configuration register indexes
	localparam logic [7:0] REG_BOX_X    = 8'd0;
	localparam logic [7:0] REG_BOX_Y    = 8'd1;
	localparam logic [7:0] REG_BOX_Z    = 8'd2;
	localparam logic [7:0] REG_RADIUS   = 8'd3;
	localparam logic [7:0] REG_SCALE    = 8'd4;
	localparam logic [7:0] REG_RESTIT   = 8'd5;
	localparam logic [7:0] REG_FRICTION = 8'd6;
	localparam logic [7:0] REG_POS_GAIN = 8'd7;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

	// per-axis face results after stage 4; bit 0 low face, bit 1 high face
	typedef struct packed {
		logic [1:0]  act;
		logic [1:0]  pmz;
		logic [33:0] fv;
		logic [33:0] pv_lo;
		logic [33:0] pv_hi;
		logic [45:0] perr_lo;
		logic [45:0] perr_hi;
	} axis_res_t;

endpackage

`default_nettype wire

/* sv/box_boundary_impulse.sv */
// Box boundary impulse for a stream of fluid particles.
// Input transfer on s_axis: nine signed Q16.16 words, position, velocity and the
// impulse gathered so far. Output transfer on m_axis: the new total impulse, three
// saturated Q16.16 words. The particle is tested against the six faces of an
// axis-aligned box; every face it penetrates adds restitution, position
// correction and friction terms.
// Configuration: cfg_valid/cfg_index/cfg_data write one register per transfer,
// cfg_ready is always high; write only while no particle is in flight.
// The particle passes through six registered stages, s1 to s6, and m_axis_tvalid
// is the valid bit of stage 6. Throughput: one particle per cycle while the output
// is not stalled; each of the six stages takes a new particle every cycle. Each
// stage holds its valid bit; a stage moves on when it is empty or the next one
// moves, so a stalled receiver fills the bubbles first and then drops
// s_axis_tready, with nothing lost or repeated.
// Reset clears all valid bits and puts the registers to their defaults:
// box limits, radius, restitution, friction and gain zero, sim_scale 1.0.
// depends on bbi_pkg and bbi_axis
`default_nettype none

module box_boundary_impulse (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, prior_impulse_x, _y, _z
	input  logic [287:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// impulse_x, impulse_y, impulse_z
	output logic [95:0]  m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_index,
	input  logic [63:0]  cfg_data
);
	import bbi_pkg::*;

	// configuration registers
	logic [63:0] box_lim_q [3];
	logic [30:0] radius_q, scale_q, gain_q;
	logic [16:0] restit_q, friction_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_lim_q[0] <= '0;
			box_lim_q[1] <= '0;
			box_lim_q[2] <= '0;
			radius_q     <= '0;
			scale_q      <= 31'(Q_ONE);
			restit_q     <= '0;
			friction_q   <= '0;
			gain_q       <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BOX_X:    box_lim_q[0] <= cfg_data;
				REG_BOX_Y:    box_lim_q[1] <= cfg_data;
				REG_BOX_Z:    box_lim_q[2] <= cfg_data;
				REG_RADIUS:   radius_q     <= cfg_data[30:0];
				REG_SCALE:    scale_q      <= cfg_data[30:0];
				REG_RESTIT:   restit_q     <= cfg_data[16:0];
				REG_FRICTION: friction_q   <= cfg_data[16:0];
				REG_POS_GAIN: gain_q       <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// stage valids and enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;
	stage_en_t stage_en;

	always_comb begin
		en6 = !v_s6 || m_axis_tready;
		en5 = !v_s5 || en6;
		en4 = !v_s4 || en5;
		en3 = !v_s3 || en4;
		en2 = !v_s2 || en3;
		en1 = !v_s1 || en2;
		stage_en.s1 = en1;
		stage_en.s2 = en2;
		stage_en.s3 = en3;
		stage_en.s4 = en4;
	end

	assign s_axis_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_axis_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// per-axis face pipelines
	axis_res_t res [3];

	for (genvar a = 0; a < 3; a++) begin : g_axis
		bbi_axis u_axis (
			.clk           (clk),
			.en            (stage_en),
			.pos           ($signed(s_axis_tdata[32*a +: 32])),
			.vel           ($signed(s_axis_tdata[96 + 32*a +: 32])),
			.limits        (box_lim_q[a]),
			.sim_scale     (scale_q),
			.scaled_radius (radius_q),
			.position_gain (gain_q),
			.restitution   (restit_q),
			.friction      (friction_q),
			.res           (res[a])
		);
	end

	// prior impulse travels alongside
	logic signed [31:0] prior_s1 [3];
	logic signed [31:0] prior_s2 [3];
	logic signed [31:0] prior_s3 [3];
	logic signed [31:0] prior_s4 [3];
	logic signed [31:0] prior_s5 [3];

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			if (en1) prior_s1[a] <= $signed(s_axis_tdata[192 + 32*a +: 32]);
			if (en2) prior_s2[a] <= prior_s1[a];
			if (en3) prior_s3[a] <= prior_s2[a];
			if (en4) prior_s4[a] <= prior_s3[a];
			if (en5) prior_s5[a] <= prior_s4[a];
		end
	end

	// stage 5: own-axis face terms and friction count
	logic [5:0]         all_act;
	logic [46:0]        term_lo [3];
	logic [46:0]        term_hi [3];
	logic signed [47:0] own [3];
	logic [2:0]         n_fric [3];
	logic signed [37:0] fvn [3];

	logic signed [47:0] own_s5 [3];
	logic signed [37:0] fvn_s5 [3];

	always_comb begin
		all_act = {res[2].act, res[1].act, res[0].act};
		for (int a = 0; a < 3; a++) begin
			term_lo[a] = 47'(res[a].pv_lo) + 47'(res[a].perr_lo);
			term_hi[a] = 47'(res[a].pv_hi) + 47'(res[a].perr_hi);
			own[a] = (res[a].act[0] ? $signed({1'b0, term_lo[a]}) : 48'sd0)
				- (res[a].act[1] ? $signed({1'b0, term_hi[a]}) : 48'sd0);
			n_fric[a] = 3'($countones(all_act)) - 3'($countones(res[a].act))
				+ 3'($countones(res[a].act & res[a].pmz));
			fvn[a] = 38'($signed(res[a].fv)) * 38'($signed({1'b0, n_fric[a]}));
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			for (int a = 0; a < 3; a++) begin
				own_s5[a] <= own[a];
				fvn_s5[a] <= fvn[a];
			end
		end
	end

	// stage 6: total and saturation
	logic signed [51:0] acc [3];
	logic [31:0]        sat [3];
	logic [31:0]        out_s6 [3];

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			acc[a] = 52'(prior_s5[a]) + 52'(own_s5[a]) - 52'(fvn_s5[a]);
			if (acc[a][51] && !(&acc[a][50:31]))
				sat[a] = 32'h8000_0000;
			else if (!acc[a][51] && (|acc[a][50:31]))
				sat[a] = 32'h7FFF_FFFF;
			else
				sat[a] = acc[a][31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en6) begin
			for (int a = 0; a < 3; a++) out_s6[a] <= sat[a];
		end
	end

	assign m_axis_tvalid = v_s6;
	assign m_axis_tdata  = {out_s6[2], out_s6[1], out_s6[0]};

`ifndef SYNTHESIS
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> v_s1)
		else $error("accepted transfer not held in stage 1");

	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && !m_axis_tready)
			|-> !s_axis_tready)
		else $error("input taken while pipeline full and output stalled");

	a_no_contact_no_term: assert property (@(posedge clk) disable iff (!arst_n)
		(en5 && v_s4 && res[0].act == 2'b00 && res[1].act == 2'b00
			&& res[2].act == 2'b00)
		|=> (own_s5[0] == '0 && own_s5[1] == '0 && own_s5[2] == '0
			&& fvn_s5[0] == '0 && fvn_s5[1] == '0 && fvn_s5[2] == '0))
		else $error("impulse term without face contact");

	a_s5_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && en6) |=> m_axis_tvalid)
		else $error("stage 5 item lost on the way to the output");
`endif

endmodule

`default_nettype wire

/* sv/bbi_axis.sv */
// box boundary impulse: four-stage per-axis face test and impulse terms
// depends on bbi_pkg
`default_nettype none

module bbi_axis (
	input  logic               clk,
	input  bbi_pkg::stage_en_t en,
	input  logic signed [31:0] pos,
	input  logic signed [31:0] vel,
	input  logic [63:0]        limits,
	input  logic [30:0]        sim_scale,
	input  logic [30:0]        scaled_radius,
	input  logic [30:0]        position_gain,
	input  logic [16:0]        restitution,
	input  logic [16:0]        friction,
	output bbi_pkg::axis_res_t res
);
	import bbi_pkg::*;

	// stage 1: face offsets and inward normal speeds
	logic signed [31:0] lo, hi;
	logic signed [32:0] diff_lo, diff_hi, vel_neg;
	logic [31:0]        pm_lo, pm_hi;

	logic signed [32:0] diff_lo_s1, diff_hi_s1;
	logic [31:0]        pm_lo_s1, pm_hi_s1;
	logic signed [31:0] vel_s1;

	always_comb begin
		lo      = $signed(limits[31:0]);
		hi      = $signed(limits[63:32]);
		diff_lo = {pos[31], pos} - {lo[31], lo};
		diff_hi = {hi[31], hi} - {pos[31], pos};
		vel_neg = -{vel[31], vel};
		pm_lo   = (!vel_neg[32] && vel_neg != '0) ? vel_neg[31:0] : '0;
		pm_hi   = (!vel[31] && vel != '0) ? vel : '0;
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			diff_lo_s1 <= diff_lo;
			diff_hi_s1 <= diff_hi;
			pm_lo_s1   <= pm_lo;
			pm_hi_s1   <= pm_hi;
			vel_s1     <= vel;
		end
	end

	// stage 2: scale, restitution and friction products
	logic signed [64:0] prod_lo, prod_hi;
	logic [17:0]        rest_gain;
	logic [49:0]        pvp_lo, pvp_hi;
	logic signed [49:0] fvp;

	logic signed [48:0] sd_lo_s2, sd_hi_s2;
	logic [33:0]        pv_lo_s2, pv_hi_s2;
	logic signed [33:0] fv_s2;
	logic [1:0]         pmz_s2;

	always_comb begin
		prod_lo   = 65'(diff_lo_s1) * 65'($signed({1'b0, sim_scale}));
		prod_hi   = 65'(diff_hi_s1) * 65'($signed({1'b0, sim_scale}));
		rest_gain = 18'(Q_ONE) + 18'(restitution);
		pvp_lo    = 50'(pm_lo_s1) * 50'(rest_gain);
		pvp_hi    = 50'(pm_hi_s1) * 50'(rest_gain);
		fvp       = 50'(vel_s1) * 50'($signed({1'b0, friction}));
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			sd_lo_s2 <= prod_lo[64:16];
			sd_hi_s2 <= prod_hi[64:16];
			pv_lo_s2 <= pvp_lo[49:16];
			pv_hi_s2 <= pvp_hi[49:16];
			fv_s2    <= fvp[49:16];
			pmz_s2   <= {pm_hi_s1 == '0, pm_lo_s1 == '0};
		end
	end

	// stage 3: distance, contact and saturated depth
	logic signed [48:0] dist_lo, dist_hi;
	logic signed [49:0] dep_lo_w, dep_hi_w;
	logic [30:0]        dep_lo, dep_hi;

	logic [30:0]        dep_lo_s3, dep_hi_s3;
	logic [1:0]         act_s3, pmz_s3;
	logic [33:0]        pv_lo_s3, pv_hi_s3;
	logic signed [33:0] fv_s3;

	always_comb begin
		dist_lo  = sd_lo_s2 - $signed({18'b0, scaled_radius});
		dist_hi  = sd_hi_s2 - $signed({18'b0, scaled_radius});
		dep_lo_w = -{dist_lo[48], dist_lo};
		dep_hi_w = -{dist_hi[48], dist_hi};
		dep_lo   = (|dep_lo_w[49:31]) ? DEPTH_MAX : dep_lo_w[30:0];
		dep_hi   = (|dep_hi_w[49:31]) ? DEPTH_MAX : dep_hi_w[30:0];
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			dep_lo_s3 <= dep_lo;
			dep_hi_s3 <= dep_hi;
			act_s3    <= {dist_hi[48], dist_lo[48]};
			pmz_s3    <= pmz_s2;
			pv_lo_s3  <= pv_lo_s2;
			pv_hi_s3  <= pv_hi_s2;
			fv_s3     <= fv_s2;
		end
	end

	// stage 4: position correction products
	logic [61:0] perr_lo_p, perr_hi_p;

	logic [45:0]        perr_lo_s4, perr_hi_s4;
	logic [1:0]         act_s4, pmz_s4;
	logic [33:0]        pv_lo_s4, pv_hi_s4;
	logic signed [33:0] fv_s4;

	always_comb begin
		perr_lo_p = 62'(dep_lo_s3) * 62'(position_gain);
		perr_hi_p = 62'(dep_hi_s3) * 62'(position_gain);
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			perr_lo_s4 <= perr_lo_p[61:16];
			perr_hi_s4 <= perr_hi_p[61:16];
			act_s4     <= act_s3;
			pmz_s4     <= pmz_s3;
			pv_lo_s4   <= pv_lo_s3;
			pv_hi_s4   <= pv_hi_s3;
			fv_s4      <= fv_s3;
		end
	end

	always_comb begin
		res.act     = act_s4;
		res.pmz     = pmz_s4;
		res.fv      = fv_s4;
		res.pv_lo   = pv_lo_s4;
		res.pv_hi   = pv_hi_s4;
		res.perr_lo = perr_lo_s4;
		res.perr_hi = perr_hi_s4;
	end

endmodule

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps
// testbench for box_boundary_impulse: a scoreboard class predicts the total impulse of every
// particle transfer and checks each output transfer; directed and random particles, several boxes
// depends on bbi_pkg and box_boundary_impulse

module tb;
	import bbi_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 10;
	localparam int SETS = 8;
	localparam int ITEMS_PER_SET = 135;
	localparam logic [7:0] REG_UNUSED = 8'hFF;

	class impulse_scoreboard;
		longint lo_lim[3];
		longint hi_lim[3];
		longint radius = 0;
		longint scale = Q_ONE;
		longint restit = 0;
		longint fric = 0;
		longint gain = 0;
		longint vel[3];
		longint fvel[3];
		longint acc[3];
		logic [95:0] impulse_q[$];
		int errors = 0;
		string axis_name[3] = '{"x", "y", "z"};

		function void write_reg(logic [7:0] idx, logic [63:0] data);
			case (idx) inside
			REG_BOX_X, REG_BOX_Y, REG_BOX_Z: begin
				lo_lim[idx] = longint'($signed(data[31:0]));
				hi_lim[idx] = longint'($signed(data[63:32]));
			end
			REG_RADIUS: radius = longint'(data[30:0]);
			REG_SCALE: scale = longint'(data[30:0]);
			REG_RESTIT: restit = longint'(data[16:0]);
			REG_FRICTION: fric = longint'(data[16:0]);
			REG_POS_GAIN: gain = longint'(data[30:0]);
			default: ;
			endcase
		endfunction

		// low face pushes along +axis, high face along -axis
		function void add_face(int a, bit low_face, longint face_dist);
			longint depth, pm, pv, perr, t;
			int k;
			if (face_dist >= 0)
				return;
			depth = -face_dist;
			if (depth > longint'(DEPTH_MAX))
				depth = longint'(DEPTH_MAX);
			pm = low_face ? -vel[a] : vel[a];
			if (pm < 0)
				pm = 0;
			pv = (pm * (Q_ONE + restit)) >>> 16;
			perr = (depth * gain) >>> 16;
			for (k = 0; k < 3; k++) begin
				if (k == a) begin
					t = low_face ? (pv + perr) : -(pv + perr);
					if (pm == 0)
						t = t - fvel[k];
					acc[k] = acc[k] + t;
				end else begin
					acc[k] = acc[k] - fvel[k];
				end
			end
		endfunction

		function void note_particle(logic [287:0] d);
			longint p, dlo, dhi;
			logic [95:0] res;
			int a;
			for (a = 0; a < 3; a++) begin
				vel[a] = longint'($signed(d[96 + 32 * a +: 32]));
				acc[a] = longint'($signed(d[192 + 32 * a +: 32]));
				fvel[a] = (vel[a] * fric) >>> 16;
			end
			for (a = 0; a < 3; a++) begin
				p = longint'($signed(d[32 * a +: 32]));
				dlo = (((p - lo_lim[a]) * scale) >>> 16) - radius;
				dhi = (((hi_lim[a] - p) * scale) >>> 16) - radius;
				add_face(a, 1'b1, dlo);
				add_face(a, 1'b0, dhi);
			end
			for (a = 0; a < 3; a++) begin
				if (acc[a] > 64'sd2147483647)
					res[32 * a +: 32] = 32'h7FFF_FFFF;
				else if (acc[a] < -64'sd2147483648)
					res[32 * a +: 32] = 32'h8000_0000;
				else
					res[32 * a +: 32] = acc[a][31:0];
			end
			impulse_q.push_back(res);
		endfunction

		function void check_impulse(logic [95:0] got);
			logic [95:0] want;
			int a;
			if (impulse_q.size() == 0) begin
				$display("%0t unexpected impulse transfer, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = impulse_q.pop_front();
			for (a = 0; a < 3; a++) begin
				if (got[32 * a +: 32] !== want[32 * a +: 32]) begin
					$display("%0t impulse_%s expected %h actual %h", $time, axis_name[a],
						want[32 * a +: 32], got[32 * a +: 32]);
					errors++;
				end
			end
		endfunction

		function int pending();
			return impulse_q.size();
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [287:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [95:0]  m_axis_tdata;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [7:0]   cfg_index;
	logic [63:0]  cfg_data;

	logic [63:0] reg_value [0:7];
	int send_idle_pct = 32;
	int recv_idle_pct = 55;
	int quiet_cycles = 0;
	impulse_scoreboard board = new();

	box_boundary_impulse dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			board.check_impulse(m_axis_tdata);
		m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// cycles with no transfer on any channel
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [63:0] box_pair(int lo, int hi);
		return {hi, lo};
	endfunction

	function automatic logic [287:0] particle(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
			logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
			logic [31:0] ix, logic [31:0] iy, logic [31:0] iz);
		return {iz, iy, ix, vz, vy, vx, pz, py, px};
	endfunction

	function automatic void set_defaults();
		logic [7:0] idx;
		for (idx = REG_BOX_X; idx <= REG_POS_GAIN; idx++)
			reg_value[idx] = '0;
		reg_value[REG_SCALE] = 64'(Q_ONE);
	endfunction

	function automatic void set_typical();
		reg_value[REG_BOX_X] = box_pair(-10 * Q_ONE, 10 * Q_ONE);
		reg_value[REG_BOX_Y] = box_pair(-5 * Q_ONE, 20 * Q_ONE);
		reg_value[REG_BOX_Z] = box_pair(0, 8 * Q_ONE);
		reg_value[REG_RADIUS] = 64'(Q_ONE / 2);
		reg_value[REG_SCALE] = 64'(Q_ONE);
		reg_value[REG_RESTIT] = 64'(Q_ONE / 2);
		reg_value[REG_FRICTION] = 64'(Q_ONE / 4);
		reg_value[REG_POS_GAIN] = 64'(2 * Q_ONE);
	endfunction

	// full-range x box, inverted y box, zero-width z box, every coefficient but the radius at its top
	function automatic void set_extreme();
		reg_value[REG_BOX_X] = box_pair(-2147483647 - 1, 2147483647);
		reg_value[REG_BOX_Y] = box_pair(3 * Q_ONE, -3 * Q_ONE);
		reg_value[REG_BOX_Z] = box_pair(0, 0);
		reg_value[REG_RADIUS] = 64'(Q_ONE / 8);
		reg_value[REG_SCALE] = 64'h7FFF_FFFF;
		reg_value[REG_RESTIT] = 64'h1_FFFF;
		reg_value[REG_FRICTION] = 64'h1_FFFF;
		reg_value[REG_POS_GAIN] = 64'h7FFF_FFFF;
	endfunction

	function automatic void set_random();
		int a, lo, w;
		for (a = 0; a < 3; a++) begin
			lo = $urandom_range(0, 40 * Q_ONE) - 20 * Q_ONE;
			w = $urandom_range(0, 30 * Q_ONE);
			if ($urandom_range(0, 4) == 0)
				reg_value[REG_BOX_X + a] = box_pair(lo + w, lo);
			else
				reg_value[REG_BOX_X + a] = box_pair(lo, lo + w);
		end
		reg_value[REG_RADIUS] = 64'($urandom_range(0, 2 * Q_ONE));
		reg_value[REG_SCALE] = 64'($urandom_range(Q_ONE / 4, 4 * Q_ONE));
		reg_value[REG_RESTIT] = 64'($urandom_range(0, Q_ONE));
		reg_value[REG_FRICTION] = 64'($urandom_range(0, Q_ONE));
		reg_value[REG_POS_GAIN] = 64'($urandom_range(0, 16 * Q_ONE));
	endfunction

	// mostly close to a face of the current box, on either side
	function automatic logic [31:0] coord_near(int a);
		logic [31:0] lo, hi, off;
		lo = reg_value[REG_BOX_X + a][31:0];
		hi = reg_value[REG_BOX_X + a][63:32];
		off = $urandom_range(0, 3 * Q_ONE);
		case ($urandom_range(0, 9))
		0, 1: return $urandom;
		2, 3, 4: return lo + off - Q_ONE;
		5, 6, 7: return hi - off + Q_ONE;
		default: return ($signed(lo) >>> 1) + ($signed(hi) >>> 1);
		endcase
	endfunction

	function automatic logic [31:0] rand_word(int span);
		case ($urandom_range(0, 9))
		0: return $urandom;
		1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
		default: return $urandom_range(0, 2 * span) - span;
		endcase
	endfunction

	task automatic send_particle(input logic [287:0] data);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= data;
		do
			@(posedge clk);
		while (!s_axis_tready);
		board.note_particle(data);
	endtask

	task automatic drain(input int extra);
		s_axis_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic load_registers(input bit add_unused);
		logic [7:0] idx;
		logic [63:0] junk;
		for (idx = REG_BOX_X; idx <= REG_POS_GAIN; idx++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data <= reg_value[idx];
			do
				@(posedge clk);
			while (!cfg_ready);
			board.write_reg(idx, reg_value[idx]);
		end
		if (add_unused) begin
			junk = {$urandom, $urandom};
			cfg_index <= REG_UNUSED;
			cfg_data <= junk;
			do
				@(posedge clk);
			while (!cfg_ready);
			board.write_reg(REG_UNUSED, junk);
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int s, n;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		m_axis_tready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_BOX_X;
		cfg_data <= '0;
		set_defaults();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: zero-size box at the origin
		send_particle(particle(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_particle(particle(1, -1, 0, 5 * Q_ONE, -3 * Q_ONE, 2 * Q_ONE, 0, 0, 0));
		send_particle(particle(32'h7FFF_FFFF, 32'h8000_0000, 1, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0));

		drain(SETTLE_CYCLES);
		set_typical();
		load_registers(1'b1);
		send_particle(particle(0, 7 * Q_ONE, 4 * Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, -Q_ONE,
			2 * Q_ONE));
		// inward motion into the low x face
		send_particle(particle(-10 * Q_ONE, 7 * Q_ONE, 4 * Q_ONE, -3 * Q_ONE, 2 * Q_ONE, -Q_ONE,
			0, 0, 0));
		// outward motion at the high x face, all velocity counts as tangential
		send_particle(particle(10 * Q_ONE + Q_ONE / 4, 7 * Q_ONE, 4 * Q_ONE, -2 * Q_ONE, Q_ONE, 0,
			Q_ONE, Q_ONE, Q_ONE));
		send_particle(particle(-11 * Q_ONE, 7 * Q_ONE, 4 * Q_ONE, 0, 3 * Q_ONE, -3 * Q_ONE,
			0, 0, 0));
		// corner, three faces at once
		send_particle(particle(10 * Q_ONE, 20 * Q_ONE, 8 * Q_ONE, 4 * Q_ONE, 4 * Q_ONE, 4 * Q_ONE,
			0, 0, 0));
		// sum overflow both ways
		send_particle(particle(-12 * Q_ONE, 7 * Q_ONE, 4 * Q_ONE, -5 * Q_ONE, 0, 0,
			32'h7FFF_FFFF, 0, 0));
		send_particle(particle(12 * Q_ONE, 7 * Q_ONE, 4 * Q_ONE, 5 * Q_ONE, 0, 0,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
		send_particle(particle(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0));
		send_particle(particle(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));

		drain(SETTLE_CYCLES);
		set_extreme();
		load_registers(1'b0);
		send_particle(particle(32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
		// deep penetration, depth saturates
		send_particle(particle(32'h7FFF_FFFF, Q_ONE, 32'h8000_0000, 32'h8000_0000, Q_ONE,
			32'h8000_0000, 0, 0, 0));
		send_particle(particle(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_particle(particle(-1, -1, -1, -1, -1, -1, -1, -1, -1));
		send_particle(particle(1, 1, 1, 1, 1, 1, 1, 1, 1));
		send_particle(particle(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
			32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));

		for (s = 0; s < SETS; s++) begin
			drain(SETTLE_CYCLES);
			if (s < 3) begin
				send_idle_pct = 32;
				recv_idle_pct = 55;
			end else if (s < 6) begin
				send_idle_pct = 55;
				recv_idle_pct = 32;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (s)
			0: set_typical();
			2: set_extreme();
			4: begin
				set_random();
				reg_value[REG_BOX_Z] = 64'hFFFF_FFFF_FFFF_FFFF;
				reg_value[REG_SCALE] = '0;
				reg_value[REG_RADIUS] = 64'h7FFF_FFFF;
			end
			6: begin
				set_random();
				reg_value[REG_RESTIT] = 64'(Q_ONE);
				reg_value[REG_FRICTION] = 64'(Q_ONE);
				reg_value[REG_POS_GAIN] = 64'h7FFF_FFFF;
			end
			7: set_defaults();
			default: set_random();
			endcase
			load_registers(1'b0);
			for (n = 0; n < ITEMS_PER_SET; n++) begin
				if (n == ITEMS_PER_SET / 2)
					drain(1);
				send_particle(particle(coord_near(0), coord_near(1), coord_near(2),
					rand_word(4 * Q_ONE), rand_word(4 * Q_ONE), rand_word(4 * Q_ONE),
					rand_word(8 * Q_ONE), rand_word(8 * Q_ONE), rand_word(8 * Q_ONE)));
			end
		end

		drain(SETTLE_CYCLES);
		if (board.errors == 0 && board.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
